@@ rtl/core/sbpd_pkg.sv @@
// Shared constants and types for the servo bus packet deframer.
package sbpd_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W = 6;
  localparam int LEN_W = 7;
  localparam int MAX_PAYLOAD_DEF = 64;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

  typedef logic [BYTE_W-1:0] bus_byte_t;
  typedef logic [IDX_W-1:0] body_idx_t;
  typedef logic [LEN_W-1:0] body_len_t;

endpackage

@@ rtl/core/sbpd_body_store.sv @@
// Packet body buffer: one write port and one registered read port.
module sbpd_body_store
  import sbpd_pkg::*;
#(
  parameter int DEPTH = MAX_PAYLOAD_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  bus_byte_t                wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output bus_byte_t                rd_data
);

  bus_byte_t mem [DEPTH];
  bus_byte_t rd_data_r;

  // The read data register holds its value while no read is issued.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/servo_bus_packet_deframer_unit.sv @@
// Top level of the servo bus packet deframer: framing, checksum and result sequencing.
//
// The block takes one bus byte per cycle while it parses a packet: two 0xFF sync bytes,
// an id byte, a length byte and then length body bytes, the last of which is the checksum
// (the inverse of the low eight bits of id + length + instruction + parameters). A length
// below 2 or above MAX_PAYLOAD sends it back to hunting for the first sync byte, as does a
// missing second sync byte. Body bytes are written into a small synchronous memory as they
// arrive. When the checksum matches, the block stops taking input and reads the body back
// out of that memory, one entry per cycle while the output is not stalled, delivering
// length-1 result items: the instruction first, then the parameters, each tagged with the
// id, its index, the parameter count and a last mark on the final one. A good packet holds
// the input off after its checksum byte until its last result item has moved into the output
// register: a memory read, then the result items in turn. A bad checksum drops the packet
// silently and returns to hunting for the first sync byte. No input is taken while the body
// is being read back, so a read never meets a write to the same entry. The output register
// lets the next packet's bytes in while the final item of a packet still waits to be taken.
module servo_bus_packet_deframer_unit
  import sbpd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  bus_byte_t in_rx_byte,
  output logic      out_valid,
  input  logic      out_stall,
  output bus_byte_t out_servo_id,
  output body_idx_t out_byte_index,
  output bus_byte_t out_body_byte,
  output body_idx_t out_param_count,
  output logic      out_last_flag
);

  localparam int AW = $clog2(MAX_PAYLOAD);
  localparam bus_byte_t MAX_LEN = BYTE_W'(MAX_PAYLOAD);

  // Parser phases; the read-back of a good packet has a phase of its own.
  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_ID    = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_FILL  = 3'd4;
  localparam logic [2:0] PH_EMIT  = 3'd5;

  logic [2:0] phase_r, phase_nxt;
  bus_byte_t  packet_id_r, packet_id_nxt;
  body_len_t  packet_length_r, packet_length_nxt;
  body_len_t  fill_count_r, fill_count_nxt;
  bus_byte_t  running_sum_r, running_sum_nxt;
  body_idx_t  iss_idx_r, iss_idx_nxt;
  body_idx_t  pend_idx_r, pend_idx_nxt;
  logic       pending_r, pending_nxt;

  logic       out_valid_r, out_valid_nxt;
  bus_byte_t  out_servo_id_r;
  body_idx_t  out_byte_index_r;
  bus_byte_t  out_body_byte_r;
  body_idx_t  out_param_count_r;
  logic       out_last_flag_r;

  logic       in_accept;
  logic       store_wr;
  logic       out_free;
  logic       move;
  logic       issue;
  logic       pend_last;
  body_idx_t  emit_count;
  body_idx_t  param_count;
  body_len_t  fill_inc;
  bus_byte_t  rd_data;

  assign in_stall  = (phase_r == PH_EMIT);
  assign in_accept = in_valid && !in_stall;
  assign store_wr  = in_accept && (phase_r == PH_FILL);
  assign fill_inc  = fill_count_r + 7'd1;

  // A good packet yields length-1 items and carries length-2 parameters.
  assign emit_count  = IDX_W'(packet_length_r - 7'd1);
  assign param_count = IDX_W'(packet_length_r - 7'd2);

  // The memory's read register holds one item at a time; it moves into the output
  // register whenever that register is empty or is being taken in this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign move      = pending_r && out_free;
  assign issue     = (phase_r == PH_EMIT) && (iss_idx_r != emit_count) && (!pending_r || move);
  assign pend_last = ((pend_idx_r + 6'd1) == emit_count);

  sbpd_body_store #(
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (fill_count_r[AW-1:0]),
    .wr_data (in_rx_byte),
    .rd_en   (issue),
    .rd_addr (iss_idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    phase_nxt         = phase_r;
    packet_id_nxt     = packet_id_r;
    packet_length_nxt = packet_length_r;
    fill_count_nxt    = fill_count_r;
    running_sum_nxt   = running_sum_r;
    iss_idx_nxt       = iss_idx_r;
    pend_idx_nxt      = pend_idx_r;
    pending_nxt       = pending_r;

    case (phase_r)
      PH_SYNC2: begin
        if (in_accept) begin
          phase_nxt = (in_rx_byte == SYNC_BYTE) ? PH_ID : PH_SYNC1;
        end
      end
      PH_ID: begin
        if (in_accept) begin
          packet_id_nxt = in_rx_byte;
          phase_nxt     = PH_LEN;
        end
      end
      PH_LEN: begin
        if (in_accept) begin
          fill_count_nxt = '0;
          if ((in_rx_byte < 8'd2) || (in_rx_byte > MAX_LEN)) begin
            phase_nxt = PH_SYNC1;
          end else begin
            packet_length_nxt = LEN_W'(in_rx_byte);
            running_sum_nxt   = packet_id_r + in_rx_byte;
            phase_nxt         = PH_FILL;
          end
        end
      end
      PH_FILL: begin
        if (in_accept) begin
          fill_count_nxt = fill_inc;
          if (fill_inc >= packet_length_r) begin
            // Checksum byte: start the read-back only when it matches.
            if (~running_sum_r == in_rx_byte) begin
              phase_nxt   = PH_EMIT;
              iss_idx_nxt = '0;
              pending_nxt = 1'b0;
            end else begin
              phase_nxt = PH_SYNC1;
            end
          end else begin
            running_sum_nxt = running_sum_r + in_rx_byte;
          end
        end
      end
      PH_EMIT: begin
        if (issue) begin
          iss_idx_nxt  = iss_idx_r + 6'd1;
          pend_idx_nxt = iss_idx_r;
          pending_nxt  = 1'b1;
        end else if (move) begin
          pending_nxt = 1'b0;
        end
        if (move && pend_last) begin
          phase_nxt = PH_SYNC1;
        end
      end
      default: begin
        if (in_accept) begin
          phase_nxt = (in_rx_byte == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
        end
      end
    endcase
  end

  always_comb begin
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_SYNC1;
      packet_id_r     <= '0;
      packet_length_r <= '0;
      fill_count_r    <= '0;
      running_sum_r   <= '0;
      iss_idx_r       <= '0;
      pend_idx_r      <= '0;
      pending_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      packet_id_r     <= packet_id_nxt;
      packet_length_r <= packet_length_nxt;
      fill_count_r    <= fill_count_nxt;
      running_sum_r   <= running_sum_nxt;
      iss_idx_r       <= iss_idx_nxt;
      pend_idx_r      <= pend_idx_nxt;
      pending_r       <= pending_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Result payload register; it only loads when an item moves in.
  always_ff @(posedge clk) begin
    if (move) begin
      out_servo_id_r    <= packet_id_r;
      out_byte_index_r  <= pend_idx_r;
      out_body_byte_r   <= rd_data;
      out_param_count_r <= param_count;
      out_last_flag_r   <= pend_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_servo_id    = out_servo_id_r;
  assign out_byte_index  = out_byte_index_r;
  assign out_body_byte   = out_body_byte_r;
  assign out_param_count = out_param_count_r;
  assign out_last_flag   = out_last_flag_r;

`ifndef SYNTHESIS
  a_pending_in_emit : assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (phase_r == PH_EMIT))
    else $error("read data pending outside the read-back phase");

  a_emit_starts_clean : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(phase_r == PH_EMIT) |-> ((iss_idx_r == '0) && !pending_r))
    else $error("read-back began with stale sequencing state");

  a_pend_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (pend_idx_r < emit_count))
    else $error("pending item index beyond the packet body");

  a_fill_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FILL) |-> (fill_count_r < packet_length_r))
    else $error("fill count reached the packet length while filling");
`endif

endmodule
